// ===== rtl/spq_pkg.sv =====
// Package for the stable priority queue: action, status, FSM and cell codes,
// plus the control struct shared by the top level and the cell chain.
// No dependencies.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_DISPLAY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SHOW
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [VALUE_W-1:0] new_value;
    logic signed [PRIO_W-1:0]  new_prio;
    logic signed [VALUE_W-1:0] head_value;
    logic signed [PRIO_W-1:0]  head_prio;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted cell chain: holds a value and priority, and takes
// data from its left or right neighbor, the new request or the head.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic                      occupied,
  input  logic                      is_tail,
  input  logic                      prev_keep,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [PRIO_W-1:0]  left_prio,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic signed [PRIO_W-1:0]  right_prio,
  output logic                      keep,
  output logic signed [VALUE_W-1:0] value,
  output logic signed [PRIO_W-1:0]  prio
);

  logic signed [VALUE_W-1:0] value_next;
  logic signed [PRIO_W-1:0]  prio_next;

  // entry stays ahead of the new one (ties keep arrival order)
  assign keep = occupied && (prio <= ctrl.new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            value_next = ctrl.new_value;
            prio_next  = ctrl.new_prio;
          end else begin
            value_next = left_value;
            prio_next  = left_prio;
          end
        end
      end
      CELL_SHIFT: begin
        value_next = right_value;
        prio_next  = right_prio;
      end
      CELL_ROTATE: begin
        if (is_tail) begin
          value_next = ctrl.head_value;
          prio_next  = ctrl.head_prio;
        end else begin
          value_next = right_value;
          prio_next  = right_prio;
        end
      end
      default: begin
        value_next = value;
        prio_next  = prio;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable sorted priority queue built as a chain of spq_cell slots.
// Depends on spq_pkg and spq_cell.
//
// A request is taken when start is high and busy is low. For enqueue,
// dequeue and peek the chain inserts or shifts on the accepting clock and
// the single result appears with strobe in the following cycle. Display of
// N held entries keeps busy high while rotating the chain one slot per
// cycle and emitting the front entry each time, so the order is back in
// place at the end; display of an empty queue gives one empty result. The
// receiver cannot stall: each result is valid for exactly the one cycle
// strobe is high, and last marks the final result of a request.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic signed [PRIO_W-1:0]  item_priority,
  output logic                      strobe,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic signed [PRIO_W-1:0]  out_priority,
  output logic                      last
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remain, remain_next;
  logic             strobe_next;
  status_t          status_next;
  logic signed [VALUE_W-1:0] out_value_next;
  logic signed [PRIO_W-1:0]  out_priority_next;
  logic             last_next;
  logic             accept;
  cell_op_t         cell_op;
  cell_ctrl_t       ctrl;

  logic                      keep  [DEPTH];
  logic signed [VALUE_W-1:0] value [DEPTH];
  logic signed [PRIO_W-1:0]  prio  [DEPTH];

  assign accept = start && !busy;

  assign ctrl.op         = cell_op;
  assign ctrl.new_value  = item_value;
  assign ctrl.new_prio   = item_priority;
  assign ctrl.head_value = value[0];
  assign ctrl.head_prio  = prio[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .is_tail     (CNT_W'(i + 1) == count),
      .prev_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_value  (value[(i == 0) ? 0 : i - 1]),
      .left_prio   (prio[(i == 0) ? 0 : i - 1]),
      .right_value (value[(i == DEPTH - 1) ? i : i + 1]),
      .right_prio  (prio[(i == DEPTH - 1) ? i : i + 1]),
      .keep        (keep[i]),
      .value       (value[i]),
      .prio        (prio[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (accept && action_t'(action) == ACT_DISPLAY && count != '0) begin
          state_next = FSM_SHOW;
        end
      end
      FSM_SHOW: begin
        if (remain == CNT_W'(1)) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy              = 1'b0;
    cell_op           = CELL_HOLD;
    count_next        = count;
    remain_next       = remain;
    strobe_next       = 1'b0;
    status_next       = STAT_OK;
    out_value_next    = '0;
    out_priority_next = '0;
    last_next         = 1'b1;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          if (action_t'(action) == ACT_ENQUEUE) begin
            if (count == CNT_W'(DEPTH)) begin
              status_next = STAT_FULL;
            end else begin
              cell_op    = CELL_INSERT;
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            status_next = STAT_EMPTY;
          end else begin
            case (action_t'(action))
              ACT_DEQUEUE: begin
                cell_op           = CELL_SHIFT;
                count_next        = count - CNT_W'(1);
                out_value_next    = value[0];
                out_priority_next = prio[0];
              end
              ACT_PEEK: begin
                out_value_next    = value[0];
                out_priority_next = prio[0];
              end
              default: begin
                strobe_next = 1'b0;
                remain_next = count;
              end
            endcase
          end
        end
      end
      FSM_SHOW: begin
        busy              = 1'b1;
        cell_op           = CELL_ROTATE;
        strobe_next       = 1'b1;
        out_value_next    = value[0];
        out_priority_next = prio[0];
        last_next         = (remain == CNT_W'(1));
        remain_next       = remain - CNT_W'(1);
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FSM_IDLE;
      count  <= '0;
      remain <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    out_value    <= out_value_next;
    out_priority <= out_priority_next;
    last         <= last_next;
  end

endmodule
